FILE: rtl/core/ab3_pkg.sv
`timescale 1ns / 1ps

package ab3_pkg;

  // Sizes of the fields and of the history store
  localparam int ENTRIES = 16384;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int DATA_W  = 32;
  localparam int DT_W    = 24;
  localparam int PHASE_W = 2;

  // Phase codes; every other code runs the full three-level step
  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;

  // Configuration register indexes
  typedef enum logic {
    REG_TIME_STEP = 1'b0,
    REG_PHASE     = 1'b1
  } cfg_reg_t;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Arithmetic widths
  localparam int SUM_W    = 38;              // 23*n - 16*r + 5*o
  localparam int SPLIT_W  = 19;              // low part of the weighted sum
  localparam int PLO_W    = SPLIT_W + DT_W;
  localparam int PHI_W    = (SUM_W - SPLIT_W) + DT_W + 1;
  localparam int PROD_W   = 63;
  localparam int MAG_W    = PROD_W - 1;
  localparam int RND_SH   = 26;              // 12*2^24 = 3*2^26
  localparam int TR_W     = PROD_W - RND_SH;
  localparam int T_W      = 34;
  localparam int TH_W     = T_W - T_W / 2;
  localparam int TL_W     = T_W / 2;
  localparam int RECIP_SH = 35;
  localparam int RECIP_W  = 34;
  localparam int PP_W     = TH_W + RECIP_W;
  localparam int ACC_W    = 68;
  localparam int Q_W      = ACC_W - RECIP_SH;
  localparam int RES_W    = 35;

  // Half of the divisor, for rounding ties away from zero
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd6 << 24);
  // Any quotient above this saturates, so clamp there
  localparam logic [T_W-1:0] T_MAX = T_W'(64'd3 << 32);
  // floor(t/3) = (t * DIV3_RECIP) >> RECIP_SH for t below 2^35
  localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'(((64'd1 << RECIP_SH) + 64'd1) / 64'd3);

  localparam logic signed [RES_W-1:0] VAL_MAX = 35'sd2147483647;
  localparam logic signed [RES_W-1:0] VAL_MIN = -35'sd2147483648;

  // One classified transaction, history already resolved
  typedef struct packed {
    logic signed [DATA_W-1:0] new_slope;
    logic signed [DATA_W-1:0] current_value;
    logic signed [DATA_W-1:0] recent;
    logic signed [DATA_W-1:0] older;
    logic                     full;
  } ab3_item_t;

endpackage

FILE: rtl/core/ab3_front.sv
`timescale 1ns / 1ps

module ab3_front import ab3_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] new_slope,
  input  logic signed [DATA_W-1:0] current_value,
  input  logic [PHASE_W-1:0]       phase,
  input  logic [QCNT_W-1:0]        q_count,
  output logic                     push,
  output ab3_item_t                push_item
);

  logic [DATA_W-1:0] recent_mem [ENTRIES];
  logic [DATA_W-1:0] older_mem  [ENTRIES];

  logic                     fire;
  logic [QCNT_W:0]          used;
  logic                     is_first;
  logic                     is_second;
  logic                     rec_we;
  logic                     old_we;
  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_index;
  logic signed [DATA_W-1:0] s1_slope;
  logic signed [DATA_W-1:0] s1_cur;
  logic [DATA_W-1:0]        rec_q;
  logic [DATA_W-1:0]        old_q;
  logic                     fwd_rec;
  logic                     fwd_old;
  logic [DATA_W-1:0]        fwd_rec_val;
  logic [DATA_W-1:0]        fwd_old_val;
  logic [DATA_W-1:0]        eff_rec;
  logic [DATA_W-1:0]        eff_old;
  logic [DATA_W-1:0]        old_wr;
  logic                     same_index;

  // Accept only while the queue has room for everything in flight
  assign used     = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid};
  assign in_ready = used < (QCNT_W+1)'(QDEPTH);
  assign fire     = in_valid & in_ready;

  // Classify by phase
  assign is_first  = phase == PHASE_FIRST;
  assign is_second = phase == PHASE_SECOND;
  assign rec_we    = !is_first;
  assign old_we    = !is_second;

  // Resolve history: bypass the write of the transaction just ahead
  assign eff_rec    = fwd_rec ? fwd_rec_val : rec_q;
  assign eff_old    = fwd_old ? fwd_old_val : old_q;
  assign old_wr     = is_first ? s1_slope : eff_rec;
  assign same_index = s1_valid && (s1_index == entry_index);

  // Read history at acceptance
  always_ff @(posedge clk) begin
    if (fire) begin
      rec_q <= recent_mem[entry_index];
      old_q <= older_mem[entry_index];
    end
  end

  // Write history in the cycle after acceptance, once the old values are known
  always_ff @(posedge clk) begin
    if (s1_valid && rec_we) begin
      recent_mem[s1_index] <= s1_slope;
    end
    if (s1_valid && old_we) begin
      older_mem[s1_index] <= old_wr;
    end
  end

  // Advance the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_index    <= entry_index;
      s1_slope    <= new_slope;
      s1_cur      <= current_value;
      fwd_rec     <= same_index && rec_we;
      fwd_old     <= same_index && old_we;
      fwd_rec_val <= s1_slope;
      fwd_old_val <= old_wr;
    end
  end

  // Hand the classified transaction to the queue
  assign push = s1_valid;

  always_comb begin
    push_item.new_slope     = s1_slope;
    push_item.current_value = s1_cur;
    push_item.recent        = eff_rec;
    push_item.older         = eff_old;
    push_item.full          = !is_first && !is_second;
  end

endmodule

FILE: rtl/core/ab3_queue.sv
`timescale 1ns / 1ps

module ab3_queue import ab3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ab3_item_t         push_item,
  output logic              q_valid,
  input  logic              q_ready,
  output ab3_item_t         q_item,
  output logic [QCNT_W-1:0] count
);

  ab3_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign q_valid = count != '0;
  assign pop     = q_valid & q_ready;
  assign q_item  = slots[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QDEPTH)))
    else $error("queue push while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue fill level out of range");

endmodule

FILE: rtl/core/ab3_back.sv
`timescale 1ns / 1ps

module ab3_back import ab3_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [DT_W-1:0]          time_step,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  ab3_item_t                q_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] updated_value,
  output logic                     saturated
);

  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

  logic signed [SUM_W-1:0]  n0, r0, o0, sum0;
  logic signed [SUM_W-1:0]  sum1;
  logic signed [DATA_W-1:0] cur1, cur2, cur3, cur4, cur5, cur6;
  logic [PLO_W-1:0]         pp_lo2;
  logic signed [PHI_W-1:0]  pp_hi2;
  logic signed [PROD_W-1:0] prod3;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        rnd;
  logic [TR_W-1:0]          tr;
  logic [T_W-1:0]           t4;
  logic                     neg4, neg5, neg6;
  logic [PP_W-1:0]          ph5, pl5;
  logic [ACC_W-1:0]         acc6;
  logic [Q_W-1:0]           q6;
  logic signed [RES_W-1:0]  inc6, res6;
  logic signed [DATA_W-1:0] val6;
  logic                     sat6;

  // Ready ripples back through the stages
  assign rdy_out = !out_valid | out_ready;
  assign rdy6    = !v6 | rdy_out;
  assign rdy5    = !v5 | rdy6;
  assign rdy4    = !v4 | rdy5;
  assign rdy3    = !v3 | rdy4;
  assign rdy2    = !v2 | rdy3;
  assign rdy1    = !v1 | rdy2;
  assign q_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    v1 <= q_valid;
      if (rdy2)    v2 <= v1;
      if (rdy3)    v3 <= v2;
      if (rdy4)    v4 <= v3;
      if (rdy5)    v5 <= v4;
      if (rdy6)    v6 <= v5;
      if (rdy_out) out_valid <= v6;
    end
  end

  // Weighted slope sum, in twelfths
  assign n0 = SUM_W'(q_item.new_slope);
  assign r0 = SUM_W'(q_item.recent);
  assign o0 = SUM_W'(q_item.older);

  always_comb begin
    if (q_item.full) begin
      sum0 = 38'sd23 * n0 - 38'sd16 * r0 + 38'sd5 * o0;
    end else begin
      sum0 = 38'sd12 * n0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sum1 <= sum0;
      cur1 <= q_item.current_value;
    end
  end

  // Scale by dt in two partial products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      pp_lo2 <= PLO_W'(sum1[SPLIT_W-1:0]) * PLO_W'(time_step);
      pp_hi2 <= PHI_W'($signed(sum1[SUM_W-1:SPLIT_W])) *
                PHI_W'($signed({1'b0, time_step}));
      cur2   <= cur1;
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod3 <= (PROD_W'(pp_hi2) <<< SPLIT_W) + PROD_W'(pp_lo2);
      cur3  <= cur2;
    end
  end

  // Take magnitude, round, divide by 2^26 and clamp
  assign mag = prod3[PROD_W-1] ? MAG_W'(-prod3) : MAG_W'(prod3);
  assign rnd = PROD_W'(mag) + ROUND_HALF;
  assign tr  = rnd[PROD_W-1:RND_SH];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      t4   <= (tr > TR_W'(T_MAX)) ? T_MAX : tr[T_W-1:0];
      neg4 <= prod3[PROD_W-1];
      cur4 <= cur3;
    end
  end

  // Divide by three through the reciprocal, in two halves
  always_ff @(posedge clk) begin
    if (rdy5) begin
      ph5  <= PP_W'(t4[T_W-1:TL_W]) * PP_W'(DIV3_RECIP);
      pl5  <= PP_W'(t4[TL_W-1:0]) * PP_W'(DIV3_RECIP);
      neg5 <= neg4;
      cur5 <= cur4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      acc6 <= (ACC_W'(ph5) << TL_W) + ACC_W'(pl5);
      neg6 <= neg5;
      cur6 <= cur5;
    end
  end

  // Apply the increment and saturate
  assign q6   = acc6[ACC_W-1:RECIP_SH];
  assign inc6 = neg6 ? -$signed(RES_W'(q6)) : $signed(RES_W'(q6));
  assign res6 = RES_W'(cur6) + inc6;

  always_comb begin
    if (res6 > VAL_MAX) begin
      val6 = DATA_W'(VAL_MAX);
      sat6 = 1'b1;
    end else if (res6 < VAL_MIN) begin
      val6 = DATA_W'(VAL_MIN);
      sat6 = 1'b1;
    end else begin
      val6 = DATA_W'(res6);
      sat6 = 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rdy_out) begin
      updated_value <= val6;
      saturated     <= sat6;
    end
  end

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (updated_value == DATA_W'(VAL_MAX) || updated_value == DATA_W'(VAL_MIN)))
    else $error("saturated result not at a range limit");

endmodule

FILE: rtl/core/adams_bashforth3_node_update.sv
// Throughput: one transaction per cycle unless stalled; the history stores are read
//   at acceptance and written in the next cycle, with a bypass for back-to-back
//   hits on one entry.
// A 4-entry queue separates the history front end from the 6-stage arithmetic.
// Reset (synchronous, active high) clears time_step, phase and all handshake state;
//   the history stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module adams_bashforth3_node_update import ab3_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DT_W-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] new_slope,
  input  logic signed [DATA_W-1:0] current_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] updated_value,
  output logic                     saturated
);

  logic [DT_W-1:0]    time_step;
  logic [PHASE_W-1:0] phase;
  logic               push;
  ab3_item_t          push_item;
  logic               q_valid;
  logic               q_ready;
  ab3_item_t          q_item;
  logic [QCNT_W-1:0]  q_count;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= '0;
      phase     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP: time_step <= cfg_data;
        REG_PHASE:     phase     <= cfg_data[PHASE_W-1:0];
        default:       ;
      endcase
    end
  end

  ab3_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entry_index   (entry_index),
    .new_slope     (new_slope),
    .current_value (current_value),
    .phase         (phase),
    .q_count       (q_count),
    .push          (push),
    .push_item     (push_item)
  );

  ab3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .count     (q_count)
  );

  ab3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .time_step     (time_step),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .updated_value (updated_value),
    .saturated     (saturated)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ab3_pkg::*;

  // Full three-level step codes (the package names only the Euler phases)
  localparam logic [PHASE_W-1:0] PHASE_FULL     = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_FULL_ALT = 2'd3;

  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 12;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] cur;
  } slope_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clip;
  } step_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                     cfg_we = 1'b0;
  cfg_reg_t                 cfg_index = REG_TIME_STEP;
  logic [DT_W-1:0]          cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [IDX_W-1:0]         entry_index = '0;
  logic signed [DATA_W-1:0] new_slope = '0;
  logic signed [DATA_W-1:0] current_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] updated_value;
  logic                     saturated;

  adams_bashforth3_node_update i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entry_index   (entry_index),
    .new_slope     (new_slope),
    .current_value (current_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .updated_value (updated_value),
    .saturated     (saturated)
  );

  // Predictor state: registers and per-entry slope history
  logic [DT_W-1:0]          step_dt;
  logic [PHASE_W-1:0]       step_phase;
  bit signed [DATA_W-1:0]   recent_hist [ENTRIES];
  bit signed [DATA_W-1:0]   older_hist  [ENTRIES];

  // Generator bookkeeping: which history entries will have been written
  bit recent_ok [ENTRIES];
  bit older_ok  [ENTRIES];

  slope_item_t        pending_items [$];
  step_result_t       value_expect [$];
  logic [IDX_W-1:0]   sweep_entries [$];
  slope_item_t        active_item;
  int                 gap_left;
  int                 burst_left;
  int                 fail_count;
  int                 stimulus_count;
  int                 quiet_cycles;
  logic [5:0]         stall_cnt;
  logic [1:0]         stall_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_full_step(input logic [PHASE_W-1:0] ph);
    return ph != PHASE_FIRST && ph != PHASE_SECOND;
  endfunction

  // Advance one entry by one time step and record its slope in its history
  function automatic void step_entry(input slope_item_t it,
                                     output logic signed [DATA_W-1:0] val,
                                     output logic clip);
    longint          rec;
    longint          old;
    longint          wsum;
    longint          prod;
    longint          inc;
    longint          total;
    longint unsigned mag;
    longint unsigned quo;
    rec = recent_hist[it.idx];
    old = older_hist[it.idx];
    if (is_full_step(step_phase)) begin
      wsum = 23 * longint'(it.slope) - 16 * rec + 5 * old;
    end else begin
      wsum = 12 * longint'(it.slope);
    end
    prod = wsum * longint'({40'd0, step_dt});
    mag  = (prod < 0) ? longint'(-prod) : prod;
    quo  = (mag + (64'd6 << 24)) / (64'd12 << 24);
    inc  = (prod < 0) ? -longint'(quo) : longint'(quo);
    total = longint'(it.cur) + inc;
    clip = 1'b0;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
      clip  = 1'b1;
    end else if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
      clip  = 1'b1;
    end
    val = total[DATA_W-1:0];
    if (step_phase == PHASE_FIRST) begin
      older_hist[it.idx] = it.slope;
    end else if (step_phase == PHASE_SECOND) begin
      recent_hist[it.idx] = it.slope;
    end else begin
      older_hist[it.idx]  = recent_hist[it.idx];
      recent_hist[it.idx] = it.slope;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1, 2:    return $signed($urandom());
      default: return $signed(32'($urandom_range(0, 32'h003FFFFF)) - 32'h00200000);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DT_W'($urandom_range(1, 255));
      default: return DT_W'($urandom());
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_entry();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return IDX_W'(ENTRIES - 1);
      default: return IDX_W'($urandom_range(0, ENTRIES - 1));
    endcase
  endfunction

  // Queue one item and note which history it will leave behind
  task automatic push_item(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] slope,
                           input logic signed [DATA_W-1:0] cur, input logic [PHASE_W-1:0] ph);
    slope_item_t it;
    it.idx   = idx;
    it.slope = slope;
    it.cur   = cur;
    pending_items.push_back(it);
    if (ph == PHASE_FIRST) begin
      older_ok[idx] = 1'b1;
    end else if (ph == PHASE_SECOND) begin
      recent_ok[idx] = 1'b1;
    end else begin
      older_ok[idx]  = recent_ok[idx];
      recent_ok[idx] = 1'b1;
    end
  endtask

  // Wait until every queued transaction is accepted and answered
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || value_expect.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers while idle, then hand back at a falling edge
  task automatic new_phase(input logic [DT_W-1:0] dt, input logic [PHASE_W-1:0] ph);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIME_STEP;
    cfg_data  <= dt;
    @(posedge clk);
    cfg_index <= REG_PHASE;
    cfg_data  <= DT_W'(ph);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // One pass over the current entry set, starting at a random point
  task automatic run_sweep(input logic [PHASE_W-1:0] ph, input bit repeats);
    int               start;
    int               pos;
    logic [IDX_W-1:0] idx;
    new_phase(rand_dt(), ph);
    start = $urandom_range(0, sweep_entries.size() - 1);
    for (int k = 0; k < sweep_entries.size(); k++) begin
      pos = (start + k) % sweep_entries.size();
      idx = sweep_entries[pos];
      // never read history that was not written
      if (!is_full_step(ph) || (recent_ok[idx] && older_ok[idx])) begin
        push_item(idx, rand_q16(), rand_q16(), ph);
        stimulus_count++;
        if (repeats && $urandom_range(0, 7) == 0) begin
          push_item(idx, rand_q16(), rand_q16(), ph);
          stimulus_count++;
        end
      end
    end
  endtask

  // Mirror register writes into the predictor
  always @(posedge clk) begin
    if (rst) begin
      step_dt    <= '0;
      step_phase <= PHASE_FIRST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: step_dt <= cfg_data;
        REG_PHASE:     step_phase <= cfg_data[PHASE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Input driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    slope_item_t  nxt;
    step_result_t res;
    if (rst) begin
      in_valid   <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        step_entry(active_item, res.value, res.clip);
        value_expect.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          nxt = pending_items.pop_front();
          in_valid      <= 1'b1;
          active_item   <= nxt;
          entry_index   <= nxt.idx;
          new_slope     <= nxt.slope;
          current_value <= nxt.cur;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Output monitor: check each result and vary the stall pattern
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_cnt  <= '0;
      stall_mode <= '0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (value_expect.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h sat %0b", updated_value, saturated);
          fail_count++;
        end else begin
          want = value_expect.pop_front();
          if (updated_value !== want.value || saturated !== want.clip) begin
            if (fail_count < 10) begin
              $display("result mismatch: expected %h sat %0b, got %h sat %0b",
                       want.value, want.clip, updated_value, saturated);
            end
            fail_count++;
          end
        end
      end
      stall_cnt <= stall_cnt + 6'd1;
      if (stall_cnt == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ready <= (stall_cnt[1:0] == 2'b11);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stimulus_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Ties round away from zero; saturation both ways
    new_phase(24'h800000, PHASE_FIRST);
    push_item(14'd0,     32'sd1,          32'sd0,          PHASE_FIRST);
    push_item(14'd16383, -32'sd1,         32'sd0,          PHASE_FIRST);
    push_item(14'd1,     32'sh7FFFFFFF,   32'sh7FFFFFFF,   PHASE_FIRST);
    push_item(14'd2,     32'sh80000000,   32'sh80000000,   PHASE_FIRST);
    push_item(14'd3,     32'sd0,          32'sd5,          PHASE_FIRST);
    push_item(14'd4,     32'sh00010000,   -32'sd123456,    PHASE_FIRST);

    // Zero step passes values through but still records history
    new_phase('0, PHASE_SECOND);
    push_item(14'd0,     32'sh80000000,   32'sh12345678,   PHASE_SECOND);
    push_item(14'd16383, 32'sh7FFFFFFF,   -32'sd77,        PHASE_SECOND);
    push_item(14'd1,     32'sh7FFFFFFF,   32'sh7FFFFFFF,   PHASE_SECOND);
    push_item(14'd2,     32'sh80000000,   32'sh80000000,   PHASE_SECOND);
    push_item(14'd3,     32'sd7,          32'sd0,          PHASE_SECOND);
    push_item(14'd4,     -32'sd65536,     32'sd65536,      PHASE_SECOND);

    // Full step at the largest dt, back-to-back hits on one entry
    new_phase('1, PHASE_FULL);
    push_item(14'd0,     32'sh7FFFFFFF,   32'sd0,          PHASE_FULL);
    push_item(14'd0,     32'sh80000000,   32'sd0,          PHASE_FULL);
    push_item(14'd16383, 32'sh80000000,   32'sh7FFFFFFF,   PHASE_FULL);
    push_item(14'd1,     32'sh7FFFFFFF,   32'sh7FFFFFFF,   PHASE_FULL);
    push_item(14'd2,     32'sh80000000,   32'sh80000000,   PHASE_FULL);
    push_item(14'd3,     32'sd100,        -32'sd1,         PHASE_FULL);

    // Phase code three runs the full step
    new_phase(rand_dt(), PHASE_FULL_ALT);
    push_item(14'd1,     rand_q16(),      rand_q16(),      PHASE_FULL_ALT);
    push_item(14'd1,     rand_q16(),      rand_q16(),      PHASE_FULL_ALT);
    push_item(14'd4,     rand_q16(),      rand_q16(),      PHASE_FULL_ALT);

    // Random entry sets: mostly full start-up sequences, some stray Euler passes
    while (stimulus_count < RANDOM_ITEMS) begin
      sweep_entries.delete();
      repeat ($urandom_range(3, 24)) sweep_entries.push_back(rand_entry());
      if ($urandom_range(0, 9) == 0) begin
        run_sweep($urandom_range(0, 1) ? PHASE_SECOND : PHASE_FIRST, 1'b0);
      end else begin
        run_sweep(PHASE_FIRST, 1'b0);
        run_sweep(PHASE_SECOND, 1'b0);
        repeat ($urandom_range(1, 4)) begin
          run_sweep(($urandom_range(0, 3) == 0) ? PHASE_FULL_ALT : PHASE_FULL, 1'b1);
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
